FILE: hdl/c3f_pkg.sv
// Package for the 3x3 scaled convolution filter: sizes, payload types,
// sequencer states, register map and the kernel row helper.
// No dependencies.
package c3f_pkg;

  localparam int ROWS        = 1024;
  localparam int COLUMNS     = 1024;
  localparam int STORE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int POS_W       = 10;
  localparam int VALUE_W     = 35;
  localparam int ROWSUM_W    = 19;
  localparam int ACC_W       = 20;
  localparam int SCALE_W     = 16;
  localparam int COEFF_W     = 24;
  localparam int PADDR_W     = 4;

  localparam logic [COEFF_W-1:0] COEFF_TOP_RST    = 24'h00FF00;
  localparam logic [COEFF_W-1:0] COEFF_MIDDLE_RST = 24'hFF05FF;
  localparam logic [COEFF_W-1:0] COEFF_BOTTOM_RST = 24'h00FF00;
  localparam logic [SCALE_W-1:0] SCALE_RST        = 16'd256;

  typedef logic [7:0]                pixel_t;
  typedef logic [COEFF_W-1:0]        coeff_row_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          pos_t;

  typedef enum logic [1:0] {
    REG_COEFF_TOP    = 2'd0,
    REG_COEFF_MIDDLE = 2'd1,
    REG_COEFF_BOTTOM = 2'd2,
    REG_SCALE        = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROW0,
    ST_ROW1,
    ST_ROW2,
    ST_SCALE,
    ST_PUSH
  } state_t;

  // Correlate one kernel row with three pixels packed left in 7:0.
  function automatic logic signed [ROWSUM_W-1:0] row_sum(input coeff_row_t coeffs,
                                                         input coeff_row_t pixels);
    logic signed [ROWSUM_W-1:0] total;
    logic signed [16:0]         prod;
    total = '0;
    for (int k = 0; k < 3; k++) begin
      prod  = $signed(coeffs[8*k +: 8]) * $signed({1'b0, pixels[8*k +: 8]});
      total = total + ROWSUM_W'(prod);
    end
    return total;
  endfunction

endpackage

FILE: hdl/c3f_pixel_if.sv
// Input channel of the filter: one pixel per transaction.
// Depends on c3f_pkg.
interface c3f_pixel_if;
  import c3f_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

FILE: hdl/c3f_result_if.sv
// Output channel of the filter: one filtered window per transaction.
// Depends on c3f_pkg.
interface c3f_result_if;
  import c3f_pkg::*;

  logic   valid;
  logic   ready;
  value_t filtered_value;
  pos_t   out_row;
  pos_t   out_column;
  logic   last_of_frame;

  modport source (output valid, output filtered_value, output out_row,
                  output out_column, output last_of_frame, input ready);
  modport sink   (input valid, input filtered_value, input out_row,
                  input out_column, input last_of_frame, output ready);
endinterface

FILE: hdl/conv3x3_scaled_filter.sv
// 3x3 scaled convolution filter, top level.
// Depends on c3f_pkg, c3f_pixel_if and c3f_result_if.
//
// Usage:
//   pixels  - valid/ready sink of 8-bit pixels in raster order; frame_start
//             marks row 0 column 0 and restarts the position counters.
//   results - valid/ready source of one transaction per complete 3x3 window,
//             named by its top-left pixel: scale * sum(coeff * pixel), full
//             35-bit two's complement product with 8 fraction bits.
//   APB     - registers 0..3 at byte addresses 0x0, 0x4, 0x8, 0xC: top,
//             middle and bottom kernel rows (3 signed bytes each), and the
//             signed Q8.8 scale. Write only while the block is idle.
// Sequence: a pixel that completes no window is accepted, then the line
//   store is read and written back; one that completes a window also goes
//   through three row multiply-accumulates, the scale multiply, and the
//   load into the output register. With the single-port line memory and the
//   shared row multiplier, no new pixel is taken until the last one is done.
// Reset (rst, synchronous): position and window clear, registers return to
//   their defaults; the line memory is not cleared, since entries are always
//   written before they feed a result.
// A stalled receiver holds the result register; a finished window waits in
//   ST_PUSH and no new pixel is taken until the result register frees.
module conv3x3_scaled_filter (
  input  logic                             clk,
  input  logic                             rst,
  c3f_pixel_if.sink                        pixels,
  c3f_result_if.source                     results,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [c3f_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import c3f_pkg::*;

  // Configuration registers
  coeff_row_t              coeff_top;
  coeff_row_t              coeff_middle;
  coeff_row_t              coeff_bottom;
  logic [SCALE_W-1:0]      output_scale;
  reg_index_t              reg_sel;

  // Line memory: upper store in 15:8, lower store in 7:0, one entry per column
  logic [15:0]             line_mem [STORE_DEPTH];
  logic [15:0]             line_rd;
  logic [SLOT_W-1:0]       slot;

  // Position and window
  logic [ROW_W-1:0]        row_count;
  logic [COL_W-1:0]        column_count;
  logic [ROW_W-1:0]        row_eff;
  logic [COL_W-1:0]        col_eff;
  pixel_t                  win [6];
  pixel_t                  pix;

  // Per-item working registers
  logic                    has_result;
  logic                    last_flag;
  pos_t                    res_row;
  pos_t                    res_col;
  coeff_row_t              tap_top;
  coeff_row_t              tap_middle;
  coeff_row_t              tap_bottom;
  logic signed [ACC_W-1:0] acc;
  value_t                  product;

  // Output register
  logic                    out_valid;
  value_t                  out_value;
  pos_t                    out_row_q;
  pos_t                    out_col_q;
  logic                    out_last;

  state_t                  state;
  state_t                  state_next;
  logic                    accept;
  logic                    load_out;
  logic signed [ROWSUM_W-1:0] row_term;

  assign accept  = pixels.valid && pixels.ready;
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  // APB register file
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_top    <= COEFF_TOP_RST;
      coeff_middle <= COEFF_MIDDLE_RST;
      coeff_bottom <= COEFF_BOTTOM_RST;
      output_scale <= SCALE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_COEFF_TOP:    coeff_top    <= pwdata[COEFF_W-1:0];
        REG_COEFF_MIDDLE: coeff_middle <= pwdata[COEFF_W-1:0];
        REG_COEFF_BOTTOM: coeff_bottom <= pwdata[COEFF_W-1:0];
        REG_SCALE:        output_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COEFF_TOP:    prdata = {8'd0, coeff_top};
      REG_COEFF_MIDDLE: prdata = {8'd0, coeff_middle};
      REG_COEFF_BOTTOM: prdata = {8'd0, coeff_bottom};
      REG_SCALE:        prdata = {16'd0, output_scale};
      default:          prdata = '0;
    endcase
  end

  // A frame start forces the position back to the frame origin
  assign row_eff = pixels.frame_start ? '0 : row_count;
  assign col_eff = pixels.frame_start ? '0 : column_count;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    pixels.ready = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pixels.ready = 1'b1;
        if (pixels.valid) state_next = ST_READ;
      end
      ST_READ:  state_next = has_result ? ST_ROW0 : ST_IDLE;
      ST_ROW0:  state_next = ST_ROW1;
      ST_ROW1:  state_next = ST_ROW2;
      ST_ROW2:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_PUSH;
      ST_PUSH: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Line memory: read on accept, write back the shifted column in ST_READ
  always_ff @(posedge clk) begin
    if (accept) line_rd <= line_mem[col_eff[SLOT_W-1:0]];
    if (state == ST_READ) line_mem[slot] <= {line_rd[7:0], pix};
  end

  // Position counters, window and tap capture
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else begin
      if (accept) begin
        if (col_eff == COL_W'(COLUMNS - 1)) begin
          column_count <= '0;
          row_count    <= (row_eff == ROW_W'(ROWS - 1)) ? '0 : row_eff + 1'b1;
        end else begin
          column_count <= col_eff + 1'b1;
          row_count    <= row_eff;
        end
      end
      if (state == ST_READ) begin
        // advance the window one column
        win[0] <= win[1];
        win[1] <= line_rd[15:8];
        win[2] <= win[3];
        win[3] <= line_rd[7:0];
        win[4] <= win[5];
        win[5] <= pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix        <= pixels.pixel;
      slot       <= col_eff[SLOT_W-1:0];
      has_result <= (row_eff >= ROW_W'(2)) && (col_eff >= COL_W'(2));
      last_flag  <= (row_eff == ROW_W'(ROWS - 1)) && (col_eff == COL_W'(COLUMNS - 1));
      res_row    <= POS_W'(row_eff - ROW_W'(2));
      res_col    <= POS_W'(col_eff - COL_W'(2));
    end
    if (state == ST_READ) begin
      // snapshot the window before it advances
      tap_top    <= {line_rd[15:8], win[1], win[0]};
      tap_middle <= {line_rd[7:0],  win[3], win[2]};
      tap_bottom <= {pix,           win[5], win[4]};
    end
  end

  // One kernel row per cycle through the shared row multiplier
  always_comb begin
    case (state)
      ST_ROW0: row_term = row_sum(coeff_top, tap_top);
      ST_ROW1: row_term = row_sum(coeff_middle, tap_middle);
      default: row_term = row_sum(coeff_bottom, tap_bottom);
    endcase
  end

  always_ff @(posedge clk) begin
    case (state) inside
      ST_ROW0:          acc <= ACC_W'(row_term);
      ST_ROW1, ST_ROW2: acc <= acc + ACC_W'(row_term);
      ST_SCALE:         product <= VALUE_W'(acc * $signed(output_scale));
      default: ;
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= product;
      out_row_q <= res_row;
      out_col_q <= res_col;
      out_last  <= last_flag;
    end
  end

  assign results.valid          = out_valid;
  assign results.filtered_value = out_value;
  assign results.out_row        = out_row_q;
  assign results.out_column     = out_col_q;
  assign results.last_of_frame  = out_last;

endmodule

FILE: tb/conv3x3_scaled_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_scaled_filter: random pixel frames with
// random kernels and scales, checked against an in-bench window predictor.
// Depends on c3f_pkg, c3f_pixel_if, c3f_result_if and the filter RTL.
module conv3x3_scaled_filter_tb;
  import c3f_pkg::*;

  // Two full rows must pass before the first complete window.
  localparam int unsigned FILL_PIXELS    = 2 * COLUMNS;
  localparam int unsigned NO_DRAIN       = 32'hFFFF_FFFF;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned REPORT_CAP     = 100;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned RUNS_PER_PHASE = 3;

  typedef enum {PAT_RANDOM, PAT_BRIGHT, PAT_DARK, PAT_EXTREME} pixel_pattern_t;

  typedef struct {
    pixel_t pixel;
    logic   frame_start;
    bit     drain_first;  // hold this pixel back until every window is out
  } pixel_item_t;

  typedef struct {
    value_t value;
    pos_t   row;
    pos_t   column;
    logic   last;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  c3f_pixel_if  pixel_ch ();
  c3f_result_if result_ch ();

  conv3x3_scaled_filter i_dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixel_ch),
    .results (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pixels waiting to be offered, and windows predicted but not yet seen.
  pixel_item_t    pixel_backlog [$];
  window_result_t expected_windows [$];

  // Predictor state: line stores, window columns, position and registers.
  pixel_t      upper_line [STORE_DEPTH] = '{default: '0};
  pixel_t      lower_line [STORE_DEPTH] = '{default: '0};
  pixel_t      window_px [6] = '{default: '0};
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  coeff_row_t  kern_top = COEFF_TOP_RST;
  coeff_row_t  kern_mid = COEFF_MIDDLE_RST;
  coeff_row_t  kern_bot = COEFF_BOTTOM_RST;
  logic [SCALE_W-1:0] scale_q88 = SCALE_RST;

  // Handshake flags, written at the rising edge and read at the falling edge.
  bit          pixel_taken = 1'b0;
  bit          result_taken = 1'b0;

  int unsigned pixels_queued = 0;
  int unsigned pixels_accepted = 0;
  int unsigned windows_checked = 0;
  int unsigned settings_loaded = 0;
  int unsigned runs_queued = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  int unsigned send_gap = 0;
  int unsigned send_steady = 0;
  int unsigned ready_gap = 0;
  int unsigned ready_steady = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  pixel_item_t next_item;
  window_result_t oldest;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned random_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic pixel_t pattern_pixel(input pixel_pattern_t pat);
    case (pat)
      PAT_BRIGHT:  return 8'hFF;
      PAT_DARK:    return 8'h00;
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:     return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Kernel bytes lean toward the signed extremes and zero.
  function automatic coeff_row_t random_coeff_row();
    coeff_row_t row;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0:       row[8*k +: 8] = 8'h80;
        1:       row[8*k +: 8] = 8'h7F;
        2:       row[8*k +: 8] = 8'h00;
        default: row[8*k +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return row;
  endfunction

  function automatic logic [SCALE_W-1:0] random_scale();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'($urandom_range(0, 511));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One kernel row against three pixels, left pixel first.
  function automatic longint kernel_dot(input coeff_row_t k, input pixel_t a,
                                        input pixel_t b, input pixel_t c);
    return longint'($signed(k[7:0])) * longint'(a) +
           longint'($signed(k[15:8])) * longint'(b) +
           longint'($signed(k[23:16])) * longint'(c);
  endfunction

  function automatic logic [31:0] shadow_value(input reg_index_t idx);
    case (idx)
      REG_COEFF_TOP:    return 32'(kern_top);
      REG_COEFF_MIDDLE: return 32'(kern_mid);
      REG_COEFF_BOTTOM: return 32'(kern_bot);
      default:          return 32'(scale_q88);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // Advance the predicted filter by one accepted pixel; queue the window it
  // completes, if any.
  task automatic shift_in_pixel(input pixel_t pix, input logic frame_start);
    int unsigned    slot;
    pixel_t         top;
    pixel_t         mid;
    longint         acc;
    window_result_t w;
    if (frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    slot = col_pos % STORE_DEPTH;
    top  = upper_line[slot];
    mid  = lower_line[slot];
    if (row_pos >= 2 && col_pos >= 2) begin
      acc = kernel_dot(kern_top, window_px[0], window_px[1], top) +
            kernel_dot(kern_mid, window_px[2], window_px[3], mid) +
            kernel_dot(kern_bot, window_px[4], window_px[5], pix);
      acc = acc * longint'($signed(scale_q88));
      w.value  = acc[VALUE_W-1:0];
      w.row    = pos_t'(row_pos - 2);
      w.column = pos_t'(col_pos - 2);
      w.last   = (row_pos == ROWS - 1) && (col_pos == COLUMNS - 1);
      expected_windows.push_back(w);
    end
    window_px[0] = window_px[1];
    window_px[1] = top;
    window_px[2] = window_px[3];
    window_px[3] = mid;
    window_px[4] = window_px[5];
    window_px[5] = pix;
    upper_line[slot] = mid;
    lower_line[slot] = pix;
    col_pos++;
    if (col_pos >= COLUMNS) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ROWS) row_pos = 0;
    end
  endtask

  // Compare the accepted result with the oldest predicted window.
  task automatic check_window();
    if (expected_windows.size() == 0) begin
      report_mismatch("unexpected result at out_row", -1, result_ch.out_row);
    end else begin
      oldest = expected_windows.pop_front();
      if (result_ch.filtered_value !== oldest.value)
        report_mismatch("filtered_value", oldest.value, result_ch.filtered_value);
      if (result_ch.out_row !== oldest.row)
        report_mismatch("out_row", oldest.row, result_ch.out_row);
      if (result_ch.out_column !== oldest.column)
        report_mismatch("out_column", oldest.column, result_ch.out_column);
      if (result_ch.last_of_frame !== oldest.last)
        report_mismatch("last_of_frame", oldest.last, result_ch.last_of_frame);
      windows_checked++;
    end
  endtask

  // Monitor and watchdog: sample both channels at the rising edge. Check
  // results before predicting, since a result always belongs to an older pixel.
  always @(posedge clk) begin
    pixel_taken  = !rst && pixel_ch.valid && pixel_ch.ready;
    result_taken = !rst && result_ch.valid && result_ch.ready;
    if (result_taken) check_window();
    if (pixel_taken) begin
      shift_in_pixel(pixel_ch.pixel, pixel_ch.frame_start);
      pixels_accepted++;
    end
    if (pixel_taken || result_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d windows outstanding",
               idle_cycles, expected_windows.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Pixel driver: hold the offered pixel until it is taken, then advance to
  // the next one after a random gap. A pixel marked drain_first waits until
  // every predicted window has come out.
  always @(negedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
    end else if (!pixel_ch.valid || pixel_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        pixel_ch.valid <= 1'b0;
      end else if (pixel_backlog.size() > 0 &&
                   !(pixel_backlog[0].drain_first && expected_windows.size() != 0)) begin
        next_item = pixel_backlog.pop_front();
        pixel_ch.valid       <= 1'b1;
        pixel_ch.pixel       <= next_item.pixel;
        pixel_ch.frame_start <= next_item.frame_start;
        if (send_steady > 0) send_steady--;
        else if ($urandom_range(0, 199) == 0) send_steady = $urandom_range(50, 300);
        send_gap = random_gap(send_steady > 0);
      end else begin
        pixel_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off deep in a row of
  // windows so the result register and the input back up while pixels keep
  // being offered.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (!hold_done && row_pos == 2 && col_pos >= 200) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      result_ch.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      if (ready_steady > 0) ready_steady--;
      else if ($urandom_range(0, 199) == 0) ready_steady = $urandom_range(50, 300);
      ready_gap = random_gap(ready_steady > 0);
    end
  end

  task automatic read_register(input reg_index_t idx, output logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = PADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Read a register back and compare its defined bits with the shadow copy.
  task automatic check_readback(input reg_index_t idx);
    logic [31:0] readback;
    logic [31:0] field_mask;
    field_mask = (idx == REG_SCALE) ? 32'h0000_FFFF : 32'h00FF_FFFF;
    read_register(idx, readback);
    if ((readback & field_mask) !== (shadow_value(idx) & field_mask)) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s readback: expected 0x%0h, got 0x%0h", idx.name(),
               shadow_value(idx) & field_mask, readback & field_mask);
    end
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_COEFF_TOP:    kern_top  = value[COEFF_W-1:0];
      REG_COEFF_MIDDLE: kern_mid  = value[COEFF_W-1:0];
      REG_COEFF_BOTTOM: kern_bot  = value[COEFF_W-1:0];
      default:          scale_q88 = value[SCALE_W-1:0];
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_readback(idx);
  endtask

  task automatic load_kernel(input coeff_row_t top, input coeff_row_t mid,
                             input coeff_row_t bot, input logic [SCALE_W-1:0] scale);
    write_register(REG_COEFF_TOP, 32'(top));
    write_register(REG_COEFF_MIDDLE, 32'(mid));
    write_register(REG_COEFF_BOTTOM, 32'(bot));
    write_register(REG_SCALE, 32'(scale));
    settings_loaded++;
  endtask

  // Queue one run of pixels in raster order, optionally marked as a new frame.
  task automatic queue_frame(input int unsigned count, input pixel_pattern_t pat,
                             input int unsigned drain_at, input bit mark_start);
    pixel_item_t item;
    for (int unsigned i = 0; i < count; i++) begin
      item.pixel       = pattern_pixel(pat);
      item.frame_start = mark_start && (i == 0);
      item.drain_first = (i == drain_at);
      pixel_backlog.push_back(item);
      pixels_queued++;
    end
    runs_queued++;
  endtask

  // Wait for every queued pixel to be taken and every window to come out,
  // then give the last pixel's pipeline time to finish.
  task automatic wait_until_drained();
    while (pixels_accepted != pixels_queued || expected_windows.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned    run_len;
    int unsigned    drain_at;
    int unsigned    pick;
    pixel_pattern_t pat;

    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    pixel_ch.valid       = 1'b0;
    pixel_ch.pixel       = '0;
    pixel_ch.frame_start = 1'b0;
    result_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults, then a first frame that relies on the reset position
    // rather than a frame_start mark.
    for (int i = 0; i < 4; i++) check_readback(reg_index_t'(i));
    queue_frame(FILL_PIXELS + 12, PAT_RANDOM, FILL_PIXELS + 6, 1'b0);
    wait_until_drained();

    // Largest positive value: all coefficients -128, scale -128.0, white pixels.
    // The second frame restarts mid-row, right after the first windows.
    load_kernel(24'h808080, 24'h808080, 24'h808080, 16'h8000);
    queue_frame(FILL_PIXELS + 6, PAT_BRIGHT, NO_DRAIN, 1'b1);
    queue_frame(FILL_PIXELS + 5, PAT_EXTREME, NO_DRAIN, 1'b1);
    wait_until_drained();

    // Large negative values from either sign of kernel and scale.
    load_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 16'h8000);
    queue_frame(FILL_PIXELS + 6, PAT_BRIGHT, NO_DRAIN, 1'b1);
    wait_until_drained();
    load_kernel(24'h808080, 24'h808080, 24'h808080, 16'h7FFF);
    queue_frame(FILL_PIXELS + 6, PAT_EXTREME, FILL_PIXELS + 4, 1'b1);
    wait_until_drained();

    // All-zero registers and dark frame: every window must read zero.
    load_kernel(24'h000000, 24'h000000, 24'h000000, 16'h0000);
    queue_frame(FILL_PIXELS + 4, PAT_DARK, NO_DRAIN, 1'b1);
    wait_until_drained();

    // Random phases. Most runs reach complete windows; some spill into the
    // next rows without a new frame mark, and some are cut short by the next
    // frame_start. The very first run is long enough for the receiver hold-off.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_kernel(random_coeff_row(), random_coeff_row(), random_coeff_row(),
                  random_scale());
      for (int unsigned run = 0; run < RUNS_PER_PHASE; run++) begin
        pick = $urandom_range(0, 99);
        if (phase == 0 && run == 0) run_len = FILL_PIXELS + 1100;
        else if (pick < 20) run_len = $urandom_range(1, FILL_PIXELS + 40);
        else if (pick < 45) run_len = FILL_PIXELS + $urandom_range(900, 1300);
        else run_len = FILL_PIXELS + $urandom_range(3, 80);
        if (phase == 0 && run == 0) drain_at = FILL_PIXELS + 1000;
        else if (pick < 20) drain_at = NO_DRAIN;
        else drain_at = FILL_PIXELS + 2 + $urandom_range(0, run_len - FILL_PIXELS - 3);
        pick = $urandom_range(0, 99);
        if (pick < 70) pat = PAT_RANDOM;
        else if (pick < 85) pat = PAT_EXTREME;
        else if (pick < 95) pat = PAT_BRIGHT;
        else pat = PAT_DARK;
        queue_frame(run_len, pat, drain_at, 1'b1);
      end
      wait_until_drained();
    end

    if (expected_windows.size() != 0)
      report_mismatch("windows left over", 0, expected_windows.size());
    $display("summary: %0d pixels in %0d runs, %0d windows checked", pixels_accepted,
             runs_queued, windows_checked);
    $display("summary: %0d register settings, %0d mismatches", settings_loaded + 1,
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: conv3x3_scaled_filter.f
hdl/c3f_pkg.sv
hdl/c3f_pixel_if.sv
hdl/c3f_result_if.sv
hdl/conv3x3_scaled_filter.sv
tb/conv3x3_scaled_filter_tb.sv
